// ===== rtl/swfr_pkg.sv =====
// swfr_pkg: types and constants of the sync word frame receiver
// no dependencies
`timescale 1ns / 1ps
package swfr_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FRAME    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NOSYNC   = 2'd3;

  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MINLEN  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } swfr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] frame_length;
    logic [31:0] good_frame_count;
    logic [31:0] abort_count;
  } swfr_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RS_START,
    S_RS_SCAN,
    S_RS_CHECK,
    S_RS_MOVE,
    S_RS_TAIL,
    S_CHK_SYNC,
    S_CHK_LEN,
    S_CRC,
    S_CRC_END,
    S_DONE
  } swfr_state_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/sync_word_frame_receiver_crc8.sv =====
// sync_word_frame_receiver_crc8: top level, sequencer over the frame store
// depends on swfr_pkg and swfr_store
//
// channel  dir  handshake        payload
// in_      in   in_valid/stall   swfr_in_t
// out_     out  out_valid/stall  swfr_out_t
// cfg_     in   cfg_valid/ready  cfg_index, cfg_data
//
// a tick steps the idle count; a byte is appended to the store, then the held header bytes are read back
// a resync scans the store byte by byte through the single read port at each candidate
// position, then moves the bytes from the found sync word down to the start of the store
// the crc check reads the frame one byte at a time through the read port
// rst_n clears control, counters and fill count; store content is not cleared
// in_stall is high while an item is in work or its result waits
`timescale 1ns / 1ps
module sync_word_frame_receiver_crc8
  import swfr_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  swfr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output swfr_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  swfr_state_t state_r, state_nxt;
  logic [31:0] sync_r;
  logic [15:0] tmo_r;
  logic [10:0] minlen_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [31:0] good_r, good_nxt, abort_r, abort_nxt;
  logic [CW-1:0] pos_r, pos_nxt;   // candidate / crc index
  logic [CW-1:0] k_r, k_nxt;       // sub index
  logic          ph_r, ph_nxt;     // read phase
  logic [7:0]    crc_r, crc_nxt;
  logic [31:0]   win_r, win_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [1:0]    rs_ret_r, rs_ret_nxt; // 0 goes on to append, 1 to done
  logic [1:0]    st_r, st_nxt;
  logic [10:0]   len_r, len_nxt;
  logic          busy_r, busy_nxt;
  logic          ov_r, ov_nxt;
  swfr_out_t     out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  swfr_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_stall  = busy_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sync_r <= '0; tmo_r <= 16'd100; minlen_r <= 11'd10;
      fill_r <= '0; idle_r <= '0; good_r <= '0; abort_r <= '0;
      busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; idle_r <= idle_nxt;
      good_r <= good_nxt; abort_r <= abort_nxt; busy_r <= busy_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC:    sync_r   <= cfg_data;
          CFG_TIMEOUT: tmo_r    <= cfg_data[15:0];
          CFG_MINLEN:  minlen_r <= cfg_data[10:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; k_r <= k_nxt; ph_r <= ph_nxt; crc_r <= crc_nxt;
    win_r <= win_nxt; byte_r <= byte_nxt; rs_ret_r <= rs_ret_nxt;
    st_r <= st_nxt; len_r <= len_nxt; out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; idle_nxt = idle_r;
    good_nxt = good_r; abort_nxt = abort_r; pos_nxt = pos_r; k_nxt = k_r;
    ph_nxt = ph_r; crc_nxt = crc_r; win_nxt = win_r; byte_nxt = byte_r;
    rs_ret_nxt = rs_ret_r; st_nxt = st_r; len_nxt = len_r;
    busy_nxt = busy_r; ov_nxt = ov_r; out_nxt = out_r;
    wr_en = 1'b0; wr_addr = '0; wr_data = rd_data; rd_addr = '0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0; busy_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && !busy_r) begin
          busy_nxt = 1'b1; st_nxt = ST_OK; len_nxt = '0;
          byte_nxt = in_data.data_byte;
          if (in_data.op == OP_TICK) begin
            if (idle_r != 16'hffff) idle_nxt = idle_r + 16'd1;
            state_nxt = S_DONE;
          end else begin
            idle_nxt = '0;
            if (idle_r >= tmo_r) begin
              if (fill_r != '0) abort_nxt = abort_r + 32'd1;
              rs_ret_nxt = 2'd0; state_nxt = S_RS_START;
            end else begin
              rs_ret_nxt = 2'd0; state_nxt = S_CHK_SYNC; k_nxt = '1;
            end
          end
        end
      end
      // append step lands here with k_r all ones
      S_CHK_SYNC: begin
        if (k_r == '1) begin
          if (fill_r >= DEPTH_C) begin
            abort_nxt = abort_r + 32'd1; st_nxt = ST_OVERFLOW;
            rs_ret_nxt = 2'd1; state_nxt = S_RS_START;
          end else begin
            wr_en = 1'b1; wr_addr = fill_r[AW-1:0]; wr_data = byte_r;
            fill_nxt = fill_r + CW'(1);
            if (fill_r + CW'(1) < CW'(4)) state_nxt = S_DONE;
            else begin k_nxt = '0; ph_nxt = 1'b0; end
          end
        end else begin
          // read bytes 0..7 into window; bytes 0..3 are compared with the sync word, bytes 4..7 give the length
          rd_addr = k_r[AW-1:0];
          if (!ph_r) ph_nxt = 1'b1;
          else begin
            ph_nxt = 1'b0;
            win_nxt = {win_r[23:0], rd_data};
            k_nxt = k_r + CW'(1);
            if (k_r == CW'(3)) begin
              if ({win_r[23:0], rd_data} != sync_r) begin
                rs_ret_nxt = 2'd1; state_nxt = S_RS_START;
              end else if (fill_r <= CW'(7)) state_nxt = S_DONE;
            end else if (k_r == CW'(7)) begin
              state_nxt = S_CHK_LEN;
            end
          end
        end
      end
      S_CHK_LEN: begin
        if (win_r < 32'(minlen_r) || win_r > 32'(STORE_DEPTH)) begin
          abort_nxt = abort_r + 32'd1; st_nxt = ST_NOSYNC;
          rs_ret_nxt = 2'd1; state_nxt = S_RS_START;
        end else if (32'(fill_r) < win_r) state_nxt = S_DONE;
        else if (32'(fill_r) > win_r) begin
          abort_nxt = abort_r + 32'd1; st_nxt = ST_NOSYNC;
          rs_ret_nxt = 2'd1; state_nxt = S_RS_START;
        end else begin
          pos_nxt = '0; ph_nxt = 1'b0; crc_nxt = CRC_INIT; state_nxt = S_CRC;
        end
      end
      S_CRC: begin
        rd_addr = pos_r[AW-1:0];
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          if (32'(pos_r) + 32'd1 == win_r) begin
            state_nxt = S_CRC_END; byte_nxt = rd_data;
          end else begin
            crc_nxt = crc8_byte(crc_r, rd_data); pos_nxt = pos_r + CW'(1);
          end
        end
      end
      S_CRC_END: begin
        if (byte_r != crc_r) begin
          abort_nxt = abort_r + 32'd1; st_nxt = ST_NOSYNC;
          rs_ret_nxt = 2'd1; state_nxt = S_RS_START;
        end else begin
          good_nxt = good_r + 32'd1; fill_nxt = '0; st_nxt = ST_FRAME;
          len_nxt = win_r[10:0]; state_nxt = S_DONE;
        end
      end
      S_RS_START: begin
        pos_nxt = CW'(1); k_nxt = '0; ph_nxt = 1'b0; state_nxt = S_RS_SCAN;
      end
      S_RS_SCAN: begin
        if (pos_r + CW'(4) > fill_r) begin
          k_nxt = '0; ph_nxt = 1'b0; state_nxt = S_RS_TAIL;
        end else begin
          rd_addr = AW'(pos_r + k_r);
          if (!ph_r) ph_nxt = 1'b1;
          else begin
            ph_nxt = 1'b0; win_nxt = {win_r[23:0], rd_data};
            if (k_r == CW'(3)) state_nxt = S_RS_CHECK;
            else k_nxt = k_r + CW'(1);
          end
        end
      end
      S_RS_CHECK: begin
        if (win_r == sync_r) begin
          k_nxt = '0; ph_nxt = 1'b0; state_nxt = S_RS_MOVE;
        end else begin
          pos_nxt = pos_r + CW'(1); k_nxt = '0; state_nxt = S_RS_SCAN;
        end
      end
      S_RS_MOVE: begin
        if (k_r + pos_r >= fill_r) begin
          fill_nxt = fill_r - pos_r; state_nxt = S_IDLE;
        end else begin
          rd_addr = AW'(pos_r + k_r);
          if (!ph_r) ph_nxt = 1'b1;
          else begin
            ph_nxt = 1'b0; wr_en = 1'b1; wr_addr = k_r[AW-1:0];
            k_nxt = k_r + CW'(1);
          end
        end
      end
      S_RS_TAIL: begin
        if (fill_r < CW'(3)) begin
          fill_nxt = '0; state_nxt = S_IDLE;
        end else if (k_r == CW'(3)) begin
          fill_nxt = CW'(3); state_nxt = S_IDLE;
        end else begin
          rd_addr = AW'(fill_r - CW'(3) + k_r);
          if (!ph_r) ph_nxt = 1'b1;
          else begin
            ph_nxt = 1'b0; wr_en = 1'b1; wr_addr = k_r[AW-1:0];
            k_nxt = k_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
          out_nxt.status = st_r; out_nxt.frame_length = len_r;
          out_nxt.good_frame_count = good_r; out_nxt.abort_count = abort_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // resync return: to append or to result
    if ((state_r == S_RS_MOVE || state_r == S_RS_TAIL) && state_nxt == S_IDLE) begin
      if (rs_ret_r == 2'd0) begin state_nxt = S_CHK_SYNC; k_nxt = '1; end
      else state_nxt = S_DONE;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= DEPTH_C)
    else $error("fill count beyond store depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FRAME) |-> out_data.frame_length != '0)
    else $error("frame result without length");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input open while item in work");
endmodule

// ===== rtl/swfr_store.sv =====
// swfr_store: frame store, one write port and one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps
module swfr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
